/* src/radar_return_to_cartesian_unit_defines.svh */
// assertion macros for the radar return conversion unit
`ifndef RADAR_RETURN_TO_CARTESIAN_UNIT_DEFINES_SVH
`define RADAR_RETURN_TO_CARTESIAN_UNIT_DEFINES_SVH

// checked only outside reset
`define RRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("radar return conversion check failed");

// checked during reset as well
`define RRC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("radar return conversion reset check failed");

`endif

/* src/rrc_pkg.sv */
package rrc_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int NSTG       = ANGLE_BITS;
  localparam int XW         = 34;
  localparam int AW         = 16;

  localparam logic signed [XW-1:0] CORDIC_K = XW'(652032874);
  localparam logic signed [XW-1:0] QUARTER  = XW'(64'sd1 << 30);
  localparam logic signed [XW-1:0] HALF     = XW'(64'sd1 << 31);
  localparam logic signed [XW-1:0] LOW_MASK =
    ~XW'((64'sd1 << (32 - ANGLE_BITS)) - 64'sd1);

  typedef logic signed [XW-1:0] cw_t;

  function automatic cw_t atan_turn(input int i);
    logic [31:0] a;
    unique case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      default: a = 32'd81;
    endcase
    return cw_t'({2'b00, a});
  endfunction

  // binary angle to folded turn units, plus fold flag
  function automatic logic [XW:0] fold_angle(input logic signed [AW-1:0] ang);
    cw_t z;
    logic neg;
    z   = cw_t'(signed'({ang, 16'h0000})) & LOW_MASK;
    neg = 1'b0;
    if (z > QUARTER) begin
      z   = z - HALF;
      neg = 1'b1;
    end else if (z < -QUARTER) begin
      z   = z + HALF;
      neg = 1'b1;
    end
    return {neg, z};
  endfunction

endpackage

/* src/radar_return_to_cartesian_unit.sv */
// Converts one radar return (range, azimuth, elevation, Doppler, amplitude) per clock into
// a Cartesian point, the Doppler projected on x and y, and an intensity picked by
// cfg_wr_data (0 amplitude, 1 Doppler). Sines and cosines come from two rotation CORDIC
// pipelines of ANGLE_BITS stages, one iteration per stage; one return can be accepted every
// cycle while in_stall is low. The whole pipeline holds while a result waits under out_stall,
// so in_stall follows it.
module radar_return_to_cartesian_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [0:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_range,
  input  logic signed [15:0]  in_azimuth,
  input  logic signed [15:0]  in_elevation,
  input  logic signed [15:0]  in_doppler_velocity,
  input  logic signed [15:0]  in_amplitude,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [16:0]  out_pos_x,
  output logic signed [16:0]  out_pos_y,
  output logic signed [16:0]  out_pos_z,
  output logic signed [15:0]  out_vel_x,
  output logic signed [15:0]  out_vel_y,
  output logic signed [15:0]  out_intensity
);
  import rrc_pkg::*;

  `include "radar_return_to_cartesian_unit_defines.svh"

  localparam int NV = NSTG + 6;

  logic        src_r;
  logic        en;
  logic [NV:1] v_r;

  // cordic lanes: 0 azimuth, 1 elevation
  cw_t         cx_r [2][NSTG+1];
  cw_t         cy_r [2][NSTG+1];
  cw_t         cz_r [2][NSTG+1];
  logic        ng_r [2][NSTG+1];
  logic [15:0] rg_r [NSTG+1];
  logic signed [15:0] dp_r [NSTG+1];
  logic signed [15:0] it_r [NSTG+1];

  logic [XW:0] fa_nxt, fe_nxt;

  cw_t ca_r, sa_r, ce_r, se_r;
  logic [15:0] rg_a_r;
  logic signed [15:0] dp_a_r, it_a_r;

  logic signed [50:0] prxy_r, pz_r;
  logic signed [49:0] pvx_r, pvy_r;
  cw_t ca_b_r, sa_b_r;
  logic signed [15:0] it_b_r;

  logic signed [29:0] rxy_r;
  logic signed [51:0] prxy_rnd_nxt, pz_rnd_nxt;
  logic signed [50:0] pvx_rnd_nxt, pvy_rnd_nxt;
  logic signed [16:0] pz_c_r;
  logic signed [15:0] vx_c_r, vy_c_r, it_c_r;
  cw_t ca_c_r, sa_c_r;
  logic signed [21:0] pz_sh_nxt;
  logic signed [20:0] vx_sh_nxt, vy_sh_nxt;

  logic signed [63:0] ppx_r, ppy_r;
  logic signed [16:0] pz_d_r;
  logic signed [15:0] vx_d_r, vy_d_r, it_d_r;
  logic signed [64:0] ppx_rnd_nxt, ppy_rnd_nxt;
  logic signed [26:0] px_sh_nxt, py_sh_nxt;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign fa_nxt   = fold_angle(in_azimuth);
  assign fe_nxt   = fold_angle(in_elevation);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= 1'b0;
    end else if (cfg_wr_en) begin
      src_r <= cfg_wr_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NV-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0][0] <= CORDIC_K;
      cy_r[0][0] <= '0;
      cz_r[0][0] <= fa_nxt[XW-1:0];
      ng_r[0][0] <= fa_nxt[XW];
      cx_r[1][0] <= CORDIC_K;
      cy_r[1][0] <= '0;
      cz_r[1][0] <= fe_nxt[XW-1:0];
      ng_r[1][0] <= fe_nxt[XW];
      rg_r[0]    <= in_range;
      dp_r[0]    <= in_doppler_velocity;
      it_r[0]    <= src_r ? in_doppler_velocity : in_amplitude;
      for (int k = 0; k < NSTG; k++) begin
        for (int l = 0; l < 2; l++) begin
          if (!cz_r[l][k][XW-1]) begin
            cx_r[l][k+1] <= cx_r[l][k] - (cy_r[l][k] >>> k);
            cy_r[l][k+1] <= cy_r[l][k] + (cx_r[l][k] >>> k);
            cz_r[l][k+1] <= cz_r[l][k] - atan_turn(k);
          end else begin
            cx_r[l][k+1] <= cx_r[l][k] + (cy_r[l][k] >>> k);
            cy_r[l][k+1] <= cy_r[l][k] - (cx_r[l][k] >>> k);
            cz_r[l][k+1] <= cz_r[l][k] + atan_turn(k);
          end
          ng_r[l][k+1] <= ng_r[l][k];
        end
        rg_r[k+1] <= rg_r[k];
        dp_r[k+1] <= dp_r[k];
        it_r[k+1] <= it_r[k];
      end
    end
  end

  // quadrant unfold
  always_ff @(posedge clk) begin
    if (en) begin
      ca_r   <= ng_r[0][NSTG] ? -cx_r[0][NSTG] : cx_r[0][NSTG];
      sa_r   <= ng_r[0][NSTG] ? -cy_r[0][NSTG] : cy_r[0][NSTG];
      ce_r   <= ng_r[1][NSTG] ? -cx_r[1][NSTG] : cx_r[1][NSTG];
      se_r   <= ng_r[1][NSTG] ? -cy_r[1][NSTG] : cy_r[1][NSTG];
      rg_a_r <= rg_r[NSTG];
      dp_a_r <= dp_r[NSTG];
      it_a_r <= it_r[NSTG];
    end
  end

  // first products
  always_ff @(posedge clk) begin
    if (en) begin
      prxy_r <= 51'(signed'({1'b0, rg_a_r})) * 51'(ce_r);
      pz_r   <= 51'(signed'({1'b0, rg_a_r})) * 51'(se_r);
      pvx_r  <= 50'(dp_a_r) * 50'(ca_r);
      pvy_r  <= 50'(dp_a_r) * 50'(sa_r);
      ca_b_r <= ca_r;
      sa_b_r <= sa_r;
      it_b_r <= it_a_r;
    end
  end

  assign prxy_rnd_nxt = 52'(prxy_r) + 52'sd2097152;
  assign pz_rnd_nxt   = 52'(pz_r) + 52'sd536870912;
  assign pvx_rnd_nxt  = 51'(pvx_r) + 51'sd536870912;
  assign pvy_rnd_nxt  = 51'(pvy_r) + 51'sd536870912;
  assign pz_sh_nxt    = 22'(pz_rnd_nxt >>> 30);
  assign vx_sh_nxt    = 21'(pvx_rnd_nxt >>> 30);
  assign vy_sh_nxt    = 21'(pvy_rnd_nxt >>> 30);

  // round, saturate short results
  always_ff @(posedge clk) begin
    if (en) begin
      rxy_r  <= 30'(prxy_rnd_nxt >>> 22);
      if (pz_sh_nxt > 22'sd65535) begin
        pz_c_r <= 17'sd65535;
      end else if (pz_sh_nxt < -22'sd65535) begin
        pz_c_r <= -17'sd65535;
      end else begin
        pz_c_r <= 17'(pz_sh_nxt);
      end
      if (vx_sh_nxt > 21'sd32767) begin
        vx_c_r <= 16'sh7fff;
      end else if (vx_sh_nxt < -21'sd32768) begin
        vx_c_r <= 16'sh8000;
      end else begin
        vx_c_r <= 16'(vx_sh_nxt);
      end
      if (vy_sh_nxt > 21'sd32767) begin
        vy_c_r <= 16'sh7fff;
      end else if (vy_sh_nxt < -21'sd32768) begin
        vy_c_r <= 16'sh8000;
      end else begin
        vy_c_r <= 16'(vy_sh_nxt);
      end
      ca_c_r <= ca_b_r;
      sa_c_r <= sa_b_r;
      it_c_r <= it_b_r;
    end
  end

  // second products
  always_ff @(posedge clk) begin
    if (en) begin
      ppx_r  <= 64'(rxy_r) * 64'(ca_c_r);
      ppy_r  <= 64'(rxy_r) * 64'(sa_c_r);
      pz_d_r <= pz_c_r;
      vx_d_r <= vx_c_r;
      vy_d_r <= vy_c_r;
      it_d_r <= it_c_r;
    end
  end

  assign ppx_rnd_nxt = 65'(ppx_r) + (65'sd1 <<< 37);
  assign ppy_rnd_nxt = 65'(ppy_r) + (65'sd1 <<< 37);
  assign px_sh_nxt   = 27'(ppx_rnd_nxt >>> 38);
  assign py_sh_nxt   = 27'(ppy_rnd_nxt >>> 38);

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (px_sh_nxt > 27'sd65535) begin
        out_pos_x <= 17'sd65535;
      end else if (px_sh_nxt < -27'sd65535) begin
        out_pos_x <= -17'sd65535;
      end else begin
        out_pos_x <= 17'(px_sh_nxt);
      end
      if (py_sh_nxt > 27'sd65535) begin
        out_pos_y <= 17'sd65535;
      end else if (py_sh_nxt < -27'sd65535) begin
        out_pos_y <= -17'sd65535;
      end else begin
        out_pos_y <= 17'(py_sh_nxt);
      end
      out_pos_z     <= pz_d_r;
      out_vel_x     <= vx_d_r;
      out_vel_y     <= vy_d_r;
      out_intensity <= it_d_r;
    end
  end

  assign out_valid = v_r[NV];

  `RRC_ASSERT(a_stall_only_on_held_result, in_stall |-> (out_valid && out_stall))
  `RRC_ASSERT(a_pos_x_sat, out_valid |-> (out_pos_x != -17'sd65536))
  `RRC_ASSERT(a_pos_z_sat, out_valid |-> (out_pos_z != -17'sd65536))
  `RRC_ASSERT_RST(a_reset_empties, !rst_n |=> !out_valid)

endmodule
